FILE: rtl/mcg_pkg.sv
// mcg_pkg: shared types, constants and tables for the month calendar grid
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mcg_pkg;

  // grid geometry
  localparam int CELL_COUNT_DEF = 37;
  localparam int WEEK_LEN       = 7;

  // field widths
  localparam int YEAR_W = 14;
  localparam int MONTH_W = 4;
  localparam int ROW_W = 3;
  localparam int COL_W = 3;
  localparam int DAY_W = 5;
  localparam int WDAY_W = 3;
  localparam int WS_W = 2;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // front pipeline depth, items in flight count needs this many plus one codes
  localparam int FRONT_STAGES = 4;
  localparam int FLIGHT_W = 3;

  // floor(x / 25) = (x * RECIP_25) >> RECIP_SHIFT for x below 2^12
  localparam logic [12:0] RECIP_25 = 13'd5243;
  localparam int RECIP_SHIFT = 17;

  // week start codes
  localparam logic [WS_W-1:0] WS_SUNDAY   = 2'd0;
  localparam logic [WS_W-1:0] WS_MONDAY   = 2'd1;
  localparam logic [WS_W-1:0] WS_SATURDAY = 2'd2;

  // month codes that matter for the day count
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;

  // one queued word: weekday column of the 1st and length of the month
  typedef struct packed {
    logic [WDAY_W-1:0] start;
    logic [DAY_W-1:0]  days;
  } entry_t;

  // (2 + 2m + 3(m+1)/5) mod 7 for the shifted month m (3..15)
  function automatic logic [WDAY_W-1:0] month_term(input logic [MONTH_W-1:0] m);
    logic [WDAY_W-1:0] r;
    case (m)
      4'd3:    r = 3'd3;
      4'd4:    r = 3'd6;
      4'd5:    r = 3'd1;
      4'd6:    r = 3'd4;
      4'd7:    r = 3'd6;
      4'd8:    r = 3'd2;
      4'd9:    r = 3'd5;
      4'd10:   r = 3'd0;
      4'd11:   r = 3'd3;
      4'd12:   r = 3'd5;
      4'd13:   r = 3'd1;
      4'd14:   r = 3'd4;
      4'd15:   r = 3'd6;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/mcg_front.sv
// mcg_front: four stage pipeline that turns year and month into the weekday
// of the 1st and the month length; depends on mcg_pkg
`timescale 1ns / 1ps

module mcg_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [mcg_pkg::YEAR_W-1:0]    year_i,
  input  logic [mcg_pkg::MONTH_W-1:0]   month_i,
  input  logic [mcg_pkg::WS_W-1:0]      week_start_i,
  output logic                          push_o,
  output mcg_pkg::entry_t               push_entry_o,
  output logic [mcg_pkg::FLIGHT_W-1:0]  in_flight_o
);
  import mcg_pkg::*;

  // stage 1: shifted year and month
  logic                s1_v_q;
  logic [YEAR_W-1:0]   s1_year_q, s1_yv_q;
  logic [MONTH_W-1:0]  s1_month_q;
  logic [WDAY_W-1:0]   s1_mt_q;
  logic                s1_neg_q;
  // stage 2: century quotients
  logic                s2_v_q;
  logic [YEAR_W-1:0]   s2_year_q, s2_yv_q;
  logic [MONTH_W-1:0]  s2_month_q;
  logic [WDAY_W-1:0]   s2_mt_q;
  logic                s2_neg_q;
  logic [7:0]          s2_qy_q, s2_qv_q;
  // stage 3: weekday sum and day count
  logic                s3_v_q;
  logic [14:0]         s3_sum_q;
  logic [DAY_W-1:0]    s3_days_q;
  // stage 4: first octal fold
  logic                s4_v_q;
  logic [5:0]          s4_fold_q;
  logic [DAY_W-1:0]    s4_days_q;

  logic                adj;
  logic                neg;
  logic [YEAR_W-1:0]   yv_d;
  logic [MONTH_W-1:0]  ms_d;
  logic [24:0]         prod_y, prod_v;
  logic [12:0]         c100_chk;
  logic                div4, div100, div400, leap;
  logic [DAY_W-1:0]    days_d;
  logic [15:0]         sum_d;
  logic [5:0]          fold_d;
  logic [3:0]          fold2;
  logic [WDAY_W-1:0]   wday, start_d;

  // stage 1 logic: Jan and Feb count as months 13 and 14 of the year before
  always_comb begin
    adj  = (month_i <= MON_FEB);
    neg  = adj && (year_i == '0);
    ms_d = adj ? MONTH_W'(month_i + 4'd12) : month_i;
    if (neg) begin
      yv_d = '0;  // year -1 handled as a constant 6 later
    end else if (adj) begin
      yv_d = year_i - YEAR_W'(1);
    end else begin
      yv_d = year_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_year_q  <= year_i;
    s1_yv_q    <= yv_d;
    s1_month_q <= month_i;
    s1_mt_q    <= month_term(ms_d);
    s1_neg_q   <= neg;
  end

  // stage 2: floor(y/100) = floor((y>>2)/25) by reciprocal
  assign prod_y = 25'(s1_year_q[YEAR_W-1:2]) * 25'(RECIP_25);
  assign prod_v = 25'(s1_yv_q[YEAR_W-1:2]) * 25'(RECIP_25);

  always_ff @(posedge clk_i) begin
    s2_year_q  <= s1_year_q;
    s2_yv_q    <= s1_yv_q;
    s2_month_q <= s1_month_q;
    s2_mt_q    <= s1_mt_q;
    s2_neg_q   <= s1_neg_q;
    s2_qy_q    <= prod_y[RECIP_SHIFT +: 8];
    s2_qv_q    <= prod_v[RECIP_SHIFT +: 8];
  end

  // stage 3: leap rule and weekday sum
  always_comb begin
    c100_chk = 13'({s2_qy_q, 4'b0}) + 13'({s2_qy_q, 3'b0}) + 13'(s2_qy_q);
    div4     = (s2_year_q[1:0] == 2'b00);
    div100   = div4 && (13'(s2_year_q[YEAR_W-1:2]) == c100_chk);
    div400   = div100 && (s2_qy_q[1:0] == 2'b00);
    leap     = (div4 && !div100) || div400;
    if (s2_month_q == MON_FEB) begin
      days_d = leap ? DAY_W'(29) : DAY_W'(28);
    end else if (s2_month_q == MON_APR || s2_month_q == MON_JUN ||
                 s2_month_q == MON_SEP || s2_month_q == MON_NOV) begin
      days_d = DAY_W'(30);
    end else begin
      days_d = DAY_W'(31);
    end
    sum_d = 16'(s2_yv_q) + 16'(s2_yv_q[YEAR_W-1:2]) - 16'(s2_qv_q)
          + 16'(s2_qv_q[7:2]) + 16'(s2_mt_q) + (s2_neg_q ? 16'd6 : 16'd0);
  end

  always_ff @(posedge clk_i) begin
    s3_sum_q  <= sum_d[14:0];
    s3_days_q <= days_d;
  end

  // stage 4: mod 7 by octal digit sums, since 8 = 1 mod 7
  assign fold_d = 6'(s3_sum_q[2:0]) + 6'(s3_sum_q[5:3]) + 6'(s3_sum_q[8:6])
                + 6'(s3_sum_q[11:9]) + 6'(s3_sum_q[14:12]);

  always_ff @(posedge clk_i) begin
    s4_fold_q <= fold_d;
    s4_days_q <= s3_days_q;
  end

  // output: second fold, final correction and week start shift
  always_comb begin
    fold2 = 4'(s4_fold_q[2:0]) + 4'(s4_fold_q[5:3]);
    wday  = (fold2 >= 4'd7) ? WDAY_W'(fold2 - 4'd7) : fold2[WDAY_W-1:0];
    case (week_start_i)
      WS_SATURDAY: start_d = (wday == 3'd6) ? 3'd0 : wday + 3'd1;
      WS_MONDAY:   start_d = (wday == 3'd0) ? 3'd6 : wday - 3'd1;
      default:     start_d = wday;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  assign push_o             = s4_v_q;
  assign push_entry_o.start = start_d;
  assign push_entry_o.days  = s4_days_q;
  assign in_flight_o = FLIGHT_W'(s1_v_q) + FLIGHT_W'(s2_v_q)
                     + FLIGHT_W'(s3_v_q) + FLIGHT_W'(s4_v_q);

endmodule

FILE: rtl/mcg_queue.sv
// mcg_queue: small fifo of month words between front and back
// depends on mcg_pkg
`timescale 1ns / 1ps

module mcg_queue (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     push_i,
  input  mcg_pkg::entry_t                          push_entry_i,
  input  logic                                     pop_i,
  output mcg_pkg::entry_t                          head_o,
  output logic                                     empty_o,
  output logic [$clog2(mcg_pkg::QUEUE_DEPTH+1)-1:0] count_o
);
  import mcg_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

FILE: rtl/mcg_back.sv
// mcg_back: cell sequencer that walks the grid one cell a cycle
// depends on mcg_pkg
`timescale 1ns / 1ps

module mcg_back #(
  parameter int CELL_COUNT = mcg_pkg::CELL_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mcg_pkg::entry_t               head_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  output logic                          strobe_o,
  output logic [mcg_pkg::ROW_W-1:0]     row_o,
  output logic [mcg_pkg::COL_W-1:0]     column_o,
  output logic [mcg_pkg::DAY_W-1:0]     day_o,
  output logic                          last_o
);
  import mcg_pkg::*;

  localparam int NW = $clog2(CELL_COUNT);

  logic               active_q;
  logic [NW-1:0]      n_q;
  logic [ROW_W-1:0]   row_q;
  logic [COL_W-1:0]   col_q;
  entry_t             cur_q;
  logic               at_last;
  logic [NW:0]        rel;

  assign at_last = (n_q == NW'(CELL_COUNT - 1));
  assign pop_o   = !empty_i && (!active_q || at_last);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      n_q      <= '0;
      row_q    <= '0;
      col_q    <= '0;
    end else if (pop_o) begin
      active_q <= 1'b1;
      n_q      <= '0;
      row_q    <= '0;
      col_q    <= '0;
    end else if (active_q) begin
      if (at_last) begin
        active_q <= 1'b0;
      end
      n_q <= n_q + NW'(1);
      if (col_q == COL_W'(WEEK_LEN - 1)) begin
        col_q <= '0;
        row_q <= row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // day number relative to the 1st, blank outside the month
  always_comb begin
    rel = (NW+1)'(n_q) - (NW+1)'(cur_q.start) + (NW+1)'(1);
    if (n_q < NW'(cur_q.start) || rel > (NW+1)'(cur_q.days)) begin
      day_o = '0;
    end else begin
      day_o = rel[DAY_W-1:0];
    end
  end

  assign strobe_o = active_q;
  assign row_o    = row_q;
  assign column_o = col_q;
  assign last_o   = at_last;

endmodule

FILE: rtl/month_calendar_grid.sv
// month_calendar_grid: top level of the month calendar layout block
// depends on mcg_pkg, mcg_front, mcg_queue and mcg_back
`timescale 1ns / 1ps

// A request names a year and a month and is taken at a clock edge where start
// is high and busy is low. The block answers with CELL_COUNT grid words, one
// per cycle, in row-major order with seven columns per row; each word is valid
// for exactly one cycle while result_strobe_o is high, and last_o marks the
// final one. The receiver cannot stall the stream, so it must take every word
// as it appears. A taken request passes through the registered stages of
// calendar arithmetic into the queue; the first word of its grid is out in
// the cycle after the cell sequencer takes it from the queue. From then on
// the sequencer sets the pace: it takes the next month as it sends the last
// word of a grid, with no gap between grids while months are queued. Up to
// two months may be pending beyond the one being sent, and busy rises while
// that room is used up. The week start register is written with cfg_we_i
// and may only change while no request is pending or in flight.

module month_calendar_grid #(
  parameter int CELL_COUNT = mcg_pkg::CELL_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request
  input  logic                          start,
  output logic                          busy,
  input  logic [mcg_pkg::YEAR_W-1:0]    year_i,
  input  logic [mcg_pkg::MONTH_W-1:0]   month_i,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [mcg_pkg::WS_W-1:0]      cfg_wdata_i,
  // grid words
  output logic                          result_strobe_o,
  output logic [mcg_pkg::ROW_W-1:0]     row_o,
  output logic [mcg_pkg::COL_W-1:0]     column_o,
  output logic [mcg_pkg::DAY_W-1:0]     day_o,
  output logic                          last_o
);
  import mcg_pkg::*;

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  logic [WS_W-1:0]     week_start_q;
  logic                accept;
  logic                push;
  entry_t              push_entry;
  entry_t              head;
  logic                empty;
  logic                pop;
  logic [FLIGHT_W-1:0] in_flight;
  logic [QCW-1:0]      q_count;
  logic [FLIGHT_W:0]   pending;

  // week start register: 0 sunday, 1 monday, 2 saturday
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      week_start_q <= WS_SUNDAY;
    end else if (cfg_we_i) begin
      week_start_q <= cfg_wdata_i;
    end
  end

  // credit check: every request in the front pipe already owns a queue slot,
  // so the pipe never has to stall
  assign pending = (FLIGHT_W+1)'(in_flight) + (FLIGHT_W+1)'(q_count);
  assign busy    = (pending >= (FLIGHT_W+1)'(QUEUE_DEPTH));
  assign accept  = start && !busy;

  // front: calendar arithmetic
  mcg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (accept),
    .year_i       (year_i),
    .month_i      (month_i),
    .week_start_i (week_start_q),
    .push_o       (push),
    .push_entry_o (push_entry),
    .in_flight_o  (in_flight)
  );

  // pending months between the two halves
  mcg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (empty),
    .count_o      (q_count)
  );

  // back: one grid word per cycle
  mcg_back #(
    .CELL_COUNT (CELL_COUNT)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .empty_i  (empty),
    .pop_o    (pop),
    .strobe_o (result_strobe_o),
    .row_o    (row_o),
    .column_o (column_o),
    .day_o    (day_o),
    .last_o   (last_o)
  );

endmodule
